@@ rtl/tmcw_pkg.sv @@
// Shared types, constants and helpers for the text-mode console writer.
// Depends on nothing; every other rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package tmcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELLS      = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LEFT_W = $clog2(TAB_SPACES + 1);

  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  RESET_ATTR  = 8'h0F;
  localparam logic [15:0] BLANK_RESET = {RESET_ATTR, CH_SPACE};

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic             cell_written;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [15:0]      cell_entry;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             scrolled;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_CLEAR,
    OP_SCROLL,
    OP_CR,
    OP_NEWLINE,
    OP_PUT,
    OP_READ_OUT
  } dp_op_t;

  typedef struct packed {
    logic   accept;   // latch the incoming word
    dp_op_t op;
    logic   emit;     // report a control result (no cell written)
    logic   last;     // last flag for a put
  } ctrl_cmd_t;

  typedef struct packed {
    logic col_full;
    logic row_bottom;
    logic sweep_end;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

@@ rtl/tmcw_apb.sv @@
// Configuration register block: APB-style write/read of the text attribute.
// Depends on tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_apb (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tmcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tmcw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [7:0]                   attr
);

  logic [7:0] attr_r;
  logic [7:0] attr_nxt;
  logic       hit;

  // register 0 is the only one; the index is the word address bit
  assign hit = (paddr[2] == 1'b0);

  always_comb begin
    attr_nxt = attr_r;
    if (psel && penable && pwrite && hit) begin
      attr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tmcw_pkg::RESET_ATTR;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  assign prdata = hit ? {{(tmcw_pkg::PDATA_W - 8){1'b0}}, attr_r} : '0;
  assign pready = 1'b1;
  assign attr   = attr_r;

endmodule

@@ rtl/tmcw_ctrl.sv @@
// Controller state machine: decodes words, sequences puts, sweeps and reads.
// Depends on tmcw_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module tmcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tmcw_pkg::in_item_t   in_item,
  input  tmcw_pkg::dp_status_t stat,
  output tmcw_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  tmcw_pkg::ctrl_state_t          state_r, state_nxt;
  logic [tmcw_pkg::LEFT_W-1:0]    left_r, left_nxt;
  logic                           feed_ret_r, feed_ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tmcw_pkg::ST_INIT;
      left_r     <= '0;
      feed_ret_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      left_r     <= left_nxt;
      feed_ret_r <= feed_ret_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    left_nxt     = left_r;
    feed_ret_nxt = feed_ret_r;
    cmd.accept   = 1'b0;
    cmd.op       = tmcw_pkg::OP_NOP;
    cmd.emit     = 1'b0;
    cmd.last     = 1'b0;
    case (state_r)
      tmcw_pkg::ST_INIT: begin
        cmd.op = tmcw_pkg::OP_INIT;
        if (stat.sweep_end) begin
          state_nxt = tmcw_pkg::ST_IDLE;
        end
      end
      tmcw_pkg::ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_item.kind)
            tmcw_pkg::KIND_WRITE: begin
              case (in_item.char_code)
                tmcw_pkg::CH_CR: begin
                  cmd.op   = tmcw_pkg::OP_CR;
                  cmd.emit = 1'b1;
                end
                tmcw_pkg::CH_LF: begin
                  cmd.op   = tmcw_pkg::OP_NEWLINE;
                  cmd.emit = !stat.row_bottom;
                  if (stat.row_bottom) begin
                    feed_ret_nxt = 1'b1;
                    state_nxt    = tmcw_pkg::ST_SCROLL;
                  end
                end
                tmcw_pkg::CH_TAB: begin
                  left_nxt  = tmcw_pkg::LEFT_W'(tmcw_pkg::TAB_SPACES);
                  state_nxt = tmcw_pkg::ST_PUT;
                end
                default: begin
                  left_nxt  = tmcw_pkg::LEFT_W'(1);
                  state_nxt = tmcw_pkg::ST_PUT;
                end
              endcase
            end
            tmcw_pkg::KIND_CLEAR: state_nxt = tmcw_pkg::ST_CLEAR;
            tmcw_pkg::KIND_READ:  state_nxt = tmcw_pkg::ST_READ;
            default: ;  // unused kind: dropped
          endcase
        end
      end
      tmcw_pkg::ST_PUT: begin
        if (stat.col_full) begin
          // wrap first; the put follows on the next cycle or after the scroll
          cmd.op = tmcw_pkg::OP_NEWLINE;
          if (stat.row_bottom) begin
            feed_ret_nxt = 1'b0;
            state_nxt    = tmcw_pkg::ST_SCROLL;
          end
        end else begin
          cmd.op   = tmcw_pkg::OP_PUT;
          cmd.last = (left_r == tmcw_pkg::LEFT_W'(1));
          left_nxt = left_r - tmcw_pkg::LEFT_W'(1);
          if (left_r == tmcw_pkg::LEFT_W'(1)) begin
            state_nxt = tmcw_pkg::ST_IDLE;
          end
        end
      end
      tmcw_pkg::ST_SCROLL: begin
        cmd.op = tmcw_pkg::OP_SCROLL;
        if (stat.sweep_end) begin
          cmd.emit  = feed_ret_r;
          state_nxt = feed_ret_r ? tmcw_pkg::ST_IDLE : tmcw_pkg::ST_PUT;
        end
      end
      tmcw_pkg::ST_CLEAR: begin
        cmd.op = tmcw_pkg::OP_CLEAR;
        if (stat.sweep_end) begin
          cmd.emit  = 1'b1;
          state_nxt = tmcw_pkg::ST_IDLE;
        end
      end
      tmcw_pkg::ST_READ: begin
        cmd.op    = tmcw_pkg::OP_READ_OUT;
        state_nxt = tmcw_pkg::ST_IDLE;
      end
      default: state_nxt = tmcw_pkg::ST_INIT;
    endcase
  end

  assign busy = (state_r != tmcw_pkg::ST_IDLE);

endmodule

@@ rtl/tmcw_datapath.sv @@
// Datapath: cursor, cell memory with sweep counter, and the result register.
// Depends on tmcw_pkg; commanded by tmcw_ctrl.
`timescale 1ns / 1ps

module tmcw_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmcw_pkg::in_item_t   in_item,
  input  tmcw_pkg::ctrl_cmd_t  cmd,
  input  logic [7:0]           attr,
  output tmcw_pkg::dp_status_t stat,
  output logic                 out_valid,
  output tmcw_pkg::out_item_t  out_item
);

  localparam int AW = tmcw_pkg::ADDR_W;
  localparam int CW = tmcw_pkg::COL_W;
  localparam int RW = tmcw_pkg::ROW_W;

  logic [15:0] text_mem [tmcw_pkg::CELLS];

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          scr_r, scr_nxt, scr_cur;
  logic [AW-1:0] cnt_r, cnt_nxt;

  logic [7:0]    char_r;
  logic [RW-1:0] rrow_r;
  logic [CW-1:0] rcol_r;
  logic          in_range_r;
  logic [15:0]   rdata_r;

  logic                out_valid_r, out_valid_nxt;
  tmcw_pkg::out_item_t out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          in_range;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] cur_addr;
  logic [AW:0]   scroll_rd;
  logic [15:0]   blank_attr;
  logic [7:0]    put_char;

  assign in_range = (in_item.read_row < RW'(tmcw_pkg::ROWS)) &&
                    (in_item.read_col < CW'(tmcw_pkg::COLUMNS));
  assign in_addr    = tmcw_pkg::cell_addr(in_item.read_row, in_item.read_col);
  assign cur_addr   = tmcw_pkg::cell_addr(row_r, col_r);
  // scroll reads the cell one row ahead of the next write, in the cycle before that write
  assign scroll_rd  = {1'b0, cnt_r} + (AW + 1)'(tmcw_pkg::COLUMNS + 1);
  assign blank_attr = {attr, tmcw_pkg::CH_SPACE};
  assign put_char   = (char_r == tmcw_pkg::CH_TAB) ? tmcw_pkg::CH_SPACE : char_r;

  assign stat.col_full   = (col_r >= CW'(tmcw_pkg::COLUMNS));
  assign stat.row_bottom = (row_r == RW'(tmcw_pkg::ROWS - 1));
  assign stat.sweep_end  = (cnt_r == AW'(tmcw_pkg::CELLS - 1));

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    scr_cur       = cmd.accept ? 1'b0 : scr_r;
    scr_nxt       = scr_cur;
    cnt_nxt       = cnt_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r;
    wr_data       = blank_attr;
    rd_en         = cmd.accept && in_range;
    rd_addr       = in_addr;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (cmd.op)
      tmcw_pkg::OP_INIT: begin
        wr_en   = 1'b1;
        wr_data = tmcw_pkg::BLANK_RESET;
        cnt_nxt = stat.sweep_end ? '0 : cnt_r + AW'(1);
      end
      tmcw_pkg::OP_CLEAR: begin
        wr_en   = 1'b1;
        cnt_nxt = stat.sweep_end ? '0 : cnt_r + AW'(1);
        if (stat.sweep_end) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end
      tmcw_pkg::OP_SCROLL: begin
        wr_en   = 1'b1;
        if (cnt_r < AW'(tmcw_pkg::LAST_ROW_BASE)) begin
          wr_data = rdata_r;
        end
        rd_en   = (scroll_rd < (AW + 1)'(tmcw_pkg::CELLS));
        rd_addr = scroll_rd[AW-1:0];
        cnt_nxt = stat.sweep_end ? '0 : cnt_r + AW'(1);
      end
      tmcw_pkg::OP_CR: begin
        col_nxt = '0;
      end
      tmcw_pkg::OP_NEWLINE: begin
        col_nxt = '0;
        if (stat.row_bottom) begin
          scr_nxt = 1'b1;
          cnt_nxt = '0;
          rd_en   = 1'b1;
          rd_addr = AW'(tmcw_pkg::COLUMNS);
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
      tmcw_pkg::OP_PUT: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr, put_char};
        col_nxt = col_r + CW'(1);
      end
      default: ;
    endcase

    if (cmd.op == tmcw_pkg::OP_PUT) begin
      out_valid_nxt        = 1'b1;
      out_nxt.cell_written = 1'b1;
      out_nxt.cell_row     = row_r;
      out_nxt.cell_col     = col_r;
      out_nxt.cell_entry   = {attr, put_char};
      out_nxt.cursor_col   = col_nxt;
      out_nxt.cursor_row   = row_nxt;
      out_nxt.scrolled     = scr_cur;
      out_nxt.last         = cmd.last;
      scr_nxt              = 1'b0;
    end else if (cmd.op == tmcw_pkg::OP_READ_OUT) begin
      out_valid_nxt        = 1'b1;
      out_nxt.cell_written = 1'b0;
      out_nxt.cell_row     = rrow_r;
      out_nxt.cell_col     = rcol_r;
      out_nxt.cell_entry   = in_range_r ? rdata_r : 16'h0000;
      out_nxt.cursor_col   = col_r;
      out_nxt.cursor_row   = row_r;
      out_nxt.scrolled     = 1'b0;
      out_nxt.last         = 1'b1;
    end else if (cmd.emit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.cell_written = 1'b0;
      out_nxt.cell_row     = '0;
      out_nxt.cell_col     = '0;
      out_nxt.cell_entry   = 16'h0000;
      out_nxt.cursor_col   = col_nxt;
      out_nxt.cursor_row   = row_nxt;
      out_nxt.scrolled     = scr_cur;
      out_nxt.last         = 1'b1;
      scr_nxt              = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      scr_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      scr_r       <= scr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.accept) begin
      char_r     <= in_item.char_code;
      rrow_r     <= in_item.read_row;
      rcol_r     <= in_item.read_col;
      in_range_r <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= text_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr < AW'(tmcw_pkg::CELLS)))
    else $error("cell write beyond the store");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= CW'(tmcw_pkg::COLUMNS)) && (row_r < RW'(tmcw_pkg::ROWS)))
    else $error("cursor out of bounds");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tmcw_pkg::OP_PUT) |-> !stat.col_full)
    else $error("put issued with a wrap pending");

  a_written_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.cell_written) |->
      (out_r.cursor_col == out_r.cell_col + CW'(1)))
    else $error("cursor not advanced past written cell");

endmodule

@@ rtl/text_mode_console_writer.sv @@
// Top level of the text-mode console writer: controller, datapath, config.
// Depends on tmcw_pkg, tmcw_apb, tmcw_ctrl and tmcw_datapath.
//
//   channel   handshake                 payload
//   input     start & !busy             in_item  (tmcw_pkg::in_item_t)
//   result    out_valid, one cycle      out_item (tmcw_pkg::out_item_t)
//   config    psel & penable & pwrite   paddr, pwdata, prdata; pready tied high
//
// Return, unscrolled feed and unused kinds need only the accept; any other
// byte or read is accepted, then followed by a write or registered memory read;
// tab is accepted, then followed by TAB_SPACES puts. A pending wrap adds a feed
// step per wrapped cell; a wrap or feed on the bottom row adds a copy-and-blank
// scroll pass. Clear sweeps the store one cell a cycle. After reset a clearing
// pass runs with busy high; the receiver cannot stall.
`timescale 1ns / 1ps

module text_mode_console_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  tmcw_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output tmcw_pkg::out_item_t          out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tmcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tmcw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  tmcw_pkg::ctrl_cmd_t  cmd;
  tmcw_pkg::dp_status_t stat;
  logic [7:0]           attr;

  tmcw_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tmcw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  tmcw_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .attr      (attr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ sim/tmcw_checker.sv @@
// Result checker for the text-mode console writer: snoops the command, result and
// config channels, keeps its own screen image and compares every result word.
// Depends on tmcw_pkg for the word types, geometry and character codes.
`timescale 1ns / 1ps

module tmcw_checker #(
  parameter logic [tmcw_pkg::PADDR_W-1:0] ATTR_ADDR = '0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  tmcw_pkg::in_item_t           in_item,
  input  logic                         out_valid,
  input  tmcw_pkg::out_item_t          out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [tmcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tmcw_pkg::PDATA_W-1:0] pwdata,
  output int                           mismatches,
  output int                           pending
);
  import tmcw_pkg::*;

  logic [15:0] screen [CELLS];
  int          cur_col;
  int          cur_row;
  logic [7:0]  attr;
  int          fail_count;
  out_item_t   due_words [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    fail_count = 0;
  end

  function automatic logic [15:0] glyph(input logic [7:0] ch);
    return {attr, ch};
  endfunction

  function automatic string show(input out_item_t w);
    return $sformatf("written=%0d cell=(%0d,%0d) entry=%h cursor=(%0d,%0d) scrolled=%0d last=%0d",
                     w.cell_written, w.cell_row, w.cell_col, w.cell_entry,
                     w.cursor_row, w.cursor_col, w.scrolled, w.last);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic wipe_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = glyph(CH_SPACE);
  endtask

  // Cursor fields always carry the cursor as it stands after the word.
  task automatic report(input logic wr, input int r, input int c, input logic [15:0] entry,
                        input logic scr, input logic lst);
    out_item_t w;
    w.cell_written = wr;
    w.cell_row     = r[ROW_W-1:0];
    w.cell_col     = c[COL_W-1:0];
    w.cell_entry   = entry;
    w.cursor_col   = cur_col[COL_W-1:0];
    w.cursor_row   = cur_row[ROW_W-1:0];
    w.scrolled     = scr;
    w.last         = lst;
    due_words.push_back(w);
  endtask

  task automatic line_down(output logic scr);
    cur_col = 0;
    cur_row++;
    scr = 1'b0;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < LAST_ROW_BASE; i++) screen[i] = screen[i + COLUMNS];
      for (int i = LAST_ROW_BASE; i < CELLS; i++) screen[i] = glyph(CH_SPACE);
      cur_row = ROWS - 1;
      scr = 1'b1;
    end
  endtask

  // Pending wrap (column at the width) is resolved before the cell is stored.
  task automatic store_char(input logic [7:0] ch, input logic lst);
    logic scr;
    int   r;
    int   c;
    scr = 1'b0;
    if (cur_col >= COLUMNS) line_down(scr);
    r = cur_row;
    c = cur_col;
    screen[r * COLUMNS + c] = glyph(ch);
    cur_col++;
    report(1'b1, r, c, glyph(ch), scr, lst);
  endtask

  task automatic predict(input in_item_t w);
    logic        scr;
    int          rr;
    int          rc;
    logic [15:0] entry;
    rr = w.read_row;
    rc = w.read_col;
    case (w.kind)
      KIND_WRITE: begin
        case (w.char_code)
          CH_CR: begin
            cur_col = 0;
            report(1'b0, 0, 0, 16'h0, 1'b0, 1'b1);
          end
          CH_LF: begin
            line_down(scr);
            report(1'b0, 0, 0, 16'h0, scr, 1'b1);
          end
          CH_TAB: begin
            for (int i = 0; i < TAB_SPACES; i++) store_char(CH_SPACE, i == TAB_SPACES - 1);
          end
          default: store_char(w.char_code, 1'b1);
        endcase
      end
      KIND_CLEAR: begin
        wipe_screen();
        cur_col = 0;
        cur_row = 0;
        report(1'b0, 0, 0, 16'h0, 1'b0, 1'b1);
      end
      KIND_READ: begin
        entry = 16'h0;
        if (rr < ROWS && rc < COLUMNS) entry = screen[rr * COLUMNS + rc];
        report(1'b0, rr, rc, entry, 1'b0, 1'b1);
      end
      default: ;  // unused kind: no word, no state change
    endcase
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t exp;
    string     bad;
    if (due_words.size() == 0) begin
      note_failure($sformatf("unexpected result word: %s", show(got)));
    end else begin
      exp = due_words.pop_front();
      bad = "";
      if (got.cell_written !== exp.cell_written) bad = {bad, " cell_written"};
      if (got.cell_row     !== exp.cell_row)     bad = {bad, " cell_row"};
      if (got.cell_col     !== exp.cell_col)     bad = {bad, " cell_col"};
      if (got.cell_entry   !== exp.cell_entry)   bad = {bad, " cell_entry"};
      if (got.cursor_col   !== exp.cursor_col)   bad = {bad, " cursor_col"};
      if (got.cursor_row   !== exp.cursor_row)   bad = {bad, " cursor_row"};
      if (got.scrolled     !== exp.scrolled)     bad = {bad, " scrolled"};
      if (got.last         !== exp.last)         bad = {bad, " last"};
      if (bad != "")
        note_failure($sformatf("result mismatch in%s: expected %s, got %s",
                               bad, show(exp), show(got)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      attr    = RESET_ATTR;
      cur_col = 0;
      cur_row = 0;
      wipe_screen();
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) attr = pwdata[7:0];
      // predict first, then check this cycle's result word against the queue
      if (start && !busy) predict(in_item);
      if (out_valid) check_word(out_item);
    end
    pending    <= due_words.size();
    mismatches <= fail_count;
  end

endmodule

@@ sim/text_mode_console_writer_tb.sv @@
// Top of the console writer testbench: clock, reset, command and config stimulus.
// Depends on tmcw_pkg, the text_mode_console_writer rtl and sim/tmcw_checker.sv.
`timescale 1ns / 1ps

module text_mode_console_writer_tb;
  import tmcw_pkg::*;

  localparam logic [1:0]         KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ATTR_ADDR   = '0;
  localparam int                 CYCLE_LIMIT = 3_000_000;
  localparam int                 PHASE_WORDS = 46;

  logic               clk;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  in_item_t           in_item = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic               busy;
  logic               out_valid;
  out_item_t          out_item;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 pending;
  int                 cycle_count = 0;
  int                 words_sent  = 0;
  int                 burst_left  = 4;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  text_mode_console_writer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tmcw_checker #(.ATTR_ADDR(ATTR_ADDR)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t word_of(input logic [1:0] kind, input logic [7:0] ch,
                                       input int row, input int col);
    in_item_t w;
    w.kind      = kind;
    w.char_code = ch;
    w.read_row  = row[ROW_W-1:0];
    w.read_col  = col[COL_W-1:0];
    return w;
  endfunction

  function automatic in_item_t write_word(input logic [7:0] ch);
    return word_of(KIND_WRITE, ch, $urandom_range(0, 31), $urandom_range(0, 127));
  endfunction

  function automatic in_item_t read_word(input int row, input int col);
    return word_of(KIND_READ, 8'($urandom_range(0, 255)), row, col);
  endfunction

  // Sender: holds start until the word is taken, then maybe idles between bursts.
  task automatic push_word(input in_item_t w);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
    if (w.kind != KIND_UNUSED) words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Quiet point: all words answered and block not busy.
  task automatic idle_block();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [7:0] a);
    idle_block();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {{(PDATA_W - 8){1'b0}}, a};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_read();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40)      push_word(read_word($urandom_range(ROWS - 5, ROWS - 1), $urandom_range(0, 20)));
    else if (p < 80) push_word(read_word($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1)));
    else             push_word(read_word($urandom_range(0, 31), $urandom_range(0, 127)));
  endtask

  // One line of text: mostly short, some long enough to wrap; then CR/LF and reads.
  task automatic send_text_line();
    int p;
    int len;
    int n;
    p = $urandom_range(0, 99);
    len = (p < 70) ? $urandom_range(0, 8) : (p < 90) ? $urandom_range(9, 30) : $urandom_range(70, 100);
    for (int i = 0; i < len; i++) begin
      p = $urandom_range(0, 99);
      if (p < 8)       push_word(write_word(CH_TAB));
      else if (p < 13) send_read();
      else if (p < 30) push_word(write_word(8'($urandom_range(0, 255))));
      else             push_word(write_word(8'($urandom_range(8'h20, 8'h7E))));
    end
    p = $urandom_range(0, 99);
    if (p < 60) begin
      push_word(write_word(CH_CR));
      n = $urandom_range(1, 4);
      repeat (n) push_word(write_word(CH_LF));
    end else if (p < 80) begin
      n = $urandom_range(1, 3);
      repeat (n) push_word(write_word(CH_LF));
    end else if (p < 90) begin
      push_word(write_word(CH_CR));
    end
    n = $urandom_range(0, 3);
    repeat (n) send_read();
    if ($urandom_range(0, 5) == 0)
      push_word(word_of(KIND_UNUSED, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                        $urandom_range(0, 127)));
    if ($urandom_range(0, 49) == 0)
      push_word(word_of(KIND_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                        $urandom_range(0, 127)));
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: read corners and out-of-range cells, extremes of the byte,
    // controls, an ignored word and a clear
    push_word(read_word(0, 0));
    push_word(read_word(ROWS - 1, COLUMNS - 1));
    push_word(read_word(31, 127));
    push_word(read_word(0, COLUMNS));
    push_word(read_word(ROWS, 0));
    push_word(write_word(8'h41));
    push_word(write_word(8'h00));
    push_word(write_word(8'hFF));
    push_word(write_word(8'h1B));
    push_word(write_word(CH_TAB));
    push_word(read_word(0, 4));
    push_word(write_word(CH_CR));
    push_word(write_word(CH_SPACE));
    push_word(write_word(CH_LF));
    push_word(word_of(KIND_UNUSED, 8'hFF, 31, 127));
    push_word(read_word(0, 0));
    push_word(read_word(0, 7));
    push_word(word_of(KIND_CLEAR, 8'h00, 0, 0));
    push_word(read_word(0, 0));
    push_word(write_word(8'h5A));
    push_word(read_word(0, 0));

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_attribute(8'h00);
        1:       set_attribute(8'hFF);
        4:       set_attribute(RESET_ATTR);
        default: set_attribute(8'($urandom_range(1, 254)));
      endcase
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_text_line();
    end

    idle_block();
    repeat (CELLS + 16) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tmcw_pkg.sv
rtl/tmcw_apb.sv
rtl/tmcw_ctrl.sv
rtl/tmcw_datapath.sv
rtl/text_mode_console_writer.sv
sim/tmcw_checker.sv
sim/text_mode_console_writer_tb.sv
